// ===== rtl/xfse_pkg.sv =====
// Package for the XOR float stream encoder.
// Holds status codes, header codes, space thresholds and the result struct.
// No dependencies.
package xfse_pkg;

  localparam int unsigned VAL_W   = 64;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned USED_W  = 19;
  localparam int unsigned BYTES_W = 16;
  localparam int unsigned HDR_W   = 14;
  localparam int unsigned HLEN_W  = 4;

  localparam logic [CNT_W-1:0] ZC_NONE = 7'd64;

  // free space thresholds in bits: 9 bytes and 16 bytes
  localparam logic [USED_W-1:0] ROOM_SAME_BITS = 19'd72;
  localparam logic [USED_W-1:0] ROOM_NEW_BITS  = 19'd128;

  localparam logic [HDR_W-1:0]  HDR_ZERO     = 14'd0;
  localparam logic [HDR_W-1:0]  HDR_SAME     = 14'd2;
  localparam logic [1:0]        HDR_NEW_CTRL = 2'b11;

  localparam logic [HLEN_W-1:0] HLEN_NONE = 4'd0;
  localparam logic [HLEN_W-1:0] HLEN_ZERO = 4'd1;
  localparam logic [HLEN_W-1:0] HLEN_SAME = 4'd2;
  localparam logic [HLEN_W-1:0] HLEN_NEW  = 4'd14;

  typedef enum logic [1:0] {
    STAT_FIRST   = 2'd0,
    STAT_ENCODED = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [HDR_W-1:0]      header_bits;
    logic [HLEN_W-1:0]     header_len;
    logic [VAL_W-1:0]      payload_bits;
    logic [CNT_W-1:0]      payload_len;
  } result_t;

endpackage

// ===== rtl/xfse_zero_count.sv =====
// Leading and trailing zero counter for one 64-bit word.
// Uses xfse_pkg; counts by a six-level halving search, 64 for a zero word.
module xfse_zero_count
  import xfse_pkg::*;
(
  input  logic [VAL_W-1:0] word,
  output logic [CNT_W-1:0] lead,
  output logic [CNT_W-1:0] tail
);

  function automatic logic [CNT_W-1:0] lzc64(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] v;
    logic [5:0]       n;
    v = x;
    n = '0;
    if (v[63:32] == '0) begin n[5] = 1'b1; v = v << 32; end
    if (v[63:48] == '0) begin n[4] = 1'b1; v = v << 16; end
    if (v[63:56] == '0) begin n[3] = 1'b1; v = v << 8; end
    if (v[63:60] == '0) begin n[2] = 1'b1; v = v << 4; end
    if (v[63:62] == '0) begin n[1] = 1'b1; v = v << 2; end
    if (v[63] == 1'b0) begin n[0] = 1'b1; end
    if (x == '0) begin
      lzc64 = ZC_NONE;
    end else begin
      lzc64 = {1'b0, n};
    end
  endfunction

  logic [VAL_W-1:0] word_rev;

  always_comb begin
    for (int i = 0; i < VAL_W; i++) begin
      word_rev[i] = word[VAL_W-1-i];
    end
  end

  assign lead = lzc64(word);
  assign tail = lzc64(word_rev);

endmodule

// ===== rtl/xfse_encoder.sv =====
// Encoding step and stream state for the XOR float stream encoder.
// Uses xfse_pkg and xfse_zero_count; updates state on each step strobe.
module xfse_encoder
  import xfse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [VAL_W-1:0]   value_bits,
  input  logic [BYTES_W-1:0] buffer_bytes,
  output result_t            result
);

  logic                have_first_r, have_first_nxt;
  logic [VAL_W-1:0]    prev_value_r, prev_value_nxt;
  logic [CNT_W-1:0]    prev_lead_r, prev_lead_nxt;
  logic [CNT_W-1:0]    prev_tail_r, prev_tail_nxt;
  logic [USED_W-1:0]   bits_used_r, bits_used_nxt;

  logic [VAL_W-1:0]    xor_word;
  logic [CNT_W-1:0]    lead, tail;
  logic [USED_W-1:0]   cap_bits;
  logic [USED_W:0]     room;
  logic                room_same, room_new, same_hdr;
  logic [CNT_W-1:0]    plen;

  xfse_zero_count u_zero_count (
    .word (xor_word),
    .lead (lead),
    .tail (tail)
  );

  assign xor_word  = prev_value_r ^ value_bits;
  assign cap_bits  = {buffer_bytes, 3'b000};
  assign room      = {1'b0, cap_bits} - {1'b0, bits_used_r};
  assign room_same = !room[USED_W] && (room[USED_W-1:0] >= ROOM_SAME_BITS);
  assign room_new  = !room[USED_W] && (room[USED_W-1:0] >= ROOM_NEW_BITS);
  assign same_hdr  = (lead == prev_lead_r) && (tail == prev_tail_r);
  assign plen      = ZC_NONE - lead - tail;

  always_comb begin
    have_first_nxt = have_first_r;
    prev_value_nxt = prev_value_r;
    prev_lead_nxt  = prev_lead_r;
    prev_tail_nxt  = prev_tail_r;
    bits_used_nxt  = bits_used_r;
    result         = '0;
    result.status  = STAT_FULL;

    priority if (!have_first_r) begin
      result.status  = STAT_FIRST;
      have_first_nxt = 1'b1;
      prev_value_nxt = value_bits;
      prev_lead_nxt  = ZC_NONE;
      prev_tail_nxt  = ZC_NONE;
    end else if (!room_same) begin
      result.status = STAT_FULL;
    end else if (xor_word == '0) begin
      result.status      = STAT_ENCODED;
      result.header_bits = HDR_ZERO;
      result.header_len  = HLEN_ZERO;
      bits_used_nxt      = bits_used_r + USED_W'(HLEN_ZERO);
    end else if (same_hdr || room_new) begin
      result.status = STAT_ENCODED;
      if (same_hdr) begin
        result.header_bits = HDR_SAME;
        result.header_len  = HLEN_SAME;
      end else begin
        result.header_bits = {HDR_NEW_CTRL, lead[5:0], tail[5:0]};
        result.header_len  = HLEN_NEW;
      end
      result.payload_bits = xor_word >> tail[5:0];
      result.payload_len  = plen;
      bits_used_nxt  = bits_used_r + USED_W'(result.header_len) + USED_W'(plen);
      prev_value_nxt = value_bits;
      prev_lead_nxt  = lead;
      prev_tail_nxt  = tail;
    end else begin
      result.status = STAT_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_first_r <= 1'b0;
      prev_value_r <= '0;
      prev_lead_r  <= ZC_NONE;
      prev_tail_r  <= ZC_NONE;
      bits_used_r  <= '0;
    end else if (step) begin
      have_first_r <= have_first_nxt;
      prev_value_r <= prev_value_nxt;
      prev_lead_r  <= prev_lead_nxt;
      prev_tail_r  <= prev_tail_nxt;
      bits_used_r  <= bits_used_nxt;
    end
  end

endmodule

// ===== rtl/xor_float_stream_encoder.sv =====
// XOR float stream encoder, top level: input register, encoder, result register.
// Uses xfse_pkg and xfse_encoder.
//
// Usage: each input transaction on in_valid/in_ready carries one raw 64-bit
// double pattern. Each one yields exactly one result transaction on
// out_valid/out_ready: status, header bits and length, payload bits and length.
// The first sample after reset is stored as the reference (status 0); later
// samples are encoded against the previous one, or rejected with status 2 when
// the bit buffer lacks room, leaving the state unchanged.
// cfg_wr_en/cfg_wr_data set the buffer capacity in bytes (reset 4096); write
// it only while no transaction is in flight.
// An accepted sample goes to the input register, then its result to the result
// register, which raises out_valid. Throughput: one transaction per cycle while
// the receiver does not stall; the encode step is a single pass between them.
// Reset (rst_n low, synchronous) empties both registers and clears the stream
// state. When the receiver stalls, the result holds, one more input is taken
// into the input register, and in_ready then drops until the result drains.
module xor_float_stream_encoder
  import xfse_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VAL_W-1:0]   in_value_bits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [HDR_W-1:0]   out_header_bits,
  output logic [HLEN_W-1:0]  out_header_len,
  output logic [VAL_W-1:0]   out_payload_bits,
  output logic [CNT_W-1:0]   out_payload_len,
  input  logic               cfg_wr_en,
  input  logic [BYTES_W-1:0] cfg_wr_data
);

  logic               s1_valid_r;
  logic [VAL_W-1:0]   s1_value_r;
  logic               out_valid_r;
  result_t            out_result_r;
  logic [BYTES_W-1:0] buffer_bytes_r;
  logic               out_free, step;
  result_t            result;

  assign out_free = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;

  xfse_encoder u_encoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .value_bits   (s1_value_r),
    .buffer_bytes (buffer_bytes_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buffer_bytes_r <= 16'd4096;
    end else if (cfg_wr_en) begin
      buffer_bytes_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_value_r <= in_value_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_result_r.status;
  assign out_header_bits  = out_result_r.header_bits;
  assign out_header_len   = out_result_r.header_len;
  assign out_payload_bits = out_result_r.payload_bits;
  assign out_payload_len  = out_result_r.payload_len;

endmodule
